[sv/fcs_pkg.sv]
// ----------------------------------------------------------------------------
// fcs_pkg
// Shared types and constants for the counting semaphore with a wait queue.
// ----------------------------------------------------------------------------
package fcs_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int THREAD_BITS  = 8;
  localparam int COUNT_BITS   = 16;
  localparam int PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TOTAL_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int CODE_BITS    = 3;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CODE_BITS-1:0] CODE_GRANTED  = 3'd0;
  localparam logic [CODE_BITS-1:0] CODE_QUEUED   = 3'd1;
  localparam logic [CODE_BITS-1:0] CODE_WOKEN    = 3'd2;
  localparam logic [CODE_BITS-1:0] CODE_DONE     = 3'd3;
  localparam logic [CODE_BITS-1:0] CODE_REJECTED = 3'd4;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_PERMITS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERMIT_LIMIT    = 2'd1;

  localparam logic [COUNT_BITS-1:0] PERMIT_LIMIT_RESET = {COUNT_BITS{1'b1}};

  // shared unit modes
  localparam logic ALU_SUB     = 1'b0;
  localparam logic ALU_ADD_SAT = 1'b1;

  typedef struct packed {
    logic                   op;
    logic [THREAD_BITS-1:0] thread_id;
    logic [COUNT_BITS-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic [THREAD_BITS-1:0] target_thread;
    logic [CODE_BITS-1:0]   code;
    logic [COUNT_BITS-1:0]  permits_left;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic rd_en;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[sv/fcs_alu.sv]
// ----------------------------------------------------------------------------
// fcs_alu
// Shared permit arithmetic: compare/subtract, or add saturating at the limit.
// ----------------------------------------------------------------------------
module fcs_alu (
  input  logic                          mode,
  input  logic [fcs_pkg::COUNT_BITS-1:0] a,
  input  logic [fcs_pkg::COUNT_BITS-1:0] b,
  input  logic [fcs_pkg::COUNT_BITS-1:0] limit,
  output logic [fcs_pkg::COUNT_BITS-1:0] result,
  output logic                          ge
);
  import fcs_pkg::*;

  logic [COUNT_BITS:0] sum;
  logic [COUNT_BITS:0] diff;

  always_comb begin
    sum  = {1'b0, a} + {1'b0, b};
    diff = {1'b0, a} - {1'b0, b};
    ge   = ~diff[COUNT_BITS];
    if (mode == ALU_ADD_SAT) begin
      result = (sum > {1'b0, limit}) ? limit : sum[COUNT_BITS-1:0];
    end else begin
      result = diff[COUNT_BITS-1:0];
    end
  end

endmodule

[sv/fcs_wait_queue.sv]
// ----------------------------------------------------------------------------
// fcs_wait_queue
// Circular wait queue of thread ids and requested counts, registered head read.
// ----------------------------------------------------------------------------
module fcs_wait_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fcs_pkg::q_ctrl_t               ctrl,
  input  logic [fcs_pkg::THREAD_BITS-1:0] push_thread,
  input  logic [fcs_pkg::COUNT_BITS-1:0]  push_req,
  output logic [fcs_pkg::THREAD_BITS-1:0] rd_thread,
  output logic [fcs_pkg::COUNT_BITS-1:0]  rd_req,
  output fcs_pkg::q_stat_t               stat
);
  import fcs_pkg::*;

  localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [TOTAL_BITS-1:0] TOTAL_FULL = TOTAL_BITS'(QUEUE_DEPTH);

  logic [THREAD_BITS-1:0] thread_mem [QUEUE_DEPTH];
  logic [COUNT_BITS-1:0]  req_mem    [QUEUE_DEPTH];

  logic [PTR_BITS-1:0]   head_r, head_nxt;
  logic [PTR_BITS-1:0]   tail_r, tail_nxt;
  logic [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [THREAD_BITS-1:0] rd_thread_r;
  logic [COUNT_BITS-1:0]  rd_req_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    total_nxt = total_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      total_nxt = '0;
    end else if (ctrl.push) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      total_nxt = total_r + 1'b1;
    end else if (ctrl.pop) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      total_nxt = total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      total_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      thread_mem[tail_r] <= push_thread;
      req_mem[tail_r]    <= push_req;
    end
    if (ctrl.rd_en) begin
      rd_thread_r <= thread_mem[head_r];
      rd_req_r    <= req_mem[head_r];
    end
  end

  assign rd_thread  = rd_thread_r;
  assign rd_req     = rd_req_r;
  assign stat.full  = (total_r == TOTAL_FULL);
  assign stat.empty = (total_r == '0);

endmodule

[sv/fifo_counting_semaphore.sv]
// ----------------------------------------------------------------------------
// fifo_counting_semaphore
// Counting semaphore with a FIFO of waiting threads, run by a small sequencer
// around one shared compare/add/subtract unit.
// ----------------------------------------------------------------------------
// acquire: the result word is registered out of the S_ACQ state, busy for one cycle.
// release: the saturating add (S_REL), then per woken waiter a queue head read
//   (S_RD) and a compare/subtract (S_CHK), then the last check and the done word;
//   a queue head that does not fit is read and compared before the done word.
// one word per strobe, never held; the receiver cannot stall.
// synchronous active-low reset: zero permits, limit all ones, queue empty.
module fifo_counting_semaphore (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  fcs_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  output fcs_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fcs_pkg::COUNT_BITS-1:0]    cfg_data
);
  import fcs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACQ  = 3'd1;
  localparam logic [2:0] S_REL  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;

  logic [2:0]            state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [COUNT_BITS-1:0] permit_r, permit_nxt;
  logic [COUNT_BITS-1:0] limit_r, limit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  alu_mode;
  logic [COUNT_BITS-1:0] alu_b;
  logic [COUNT_BITS-1:0] alu_result;
  logic                  alu_ge;

  q_ctrl_t                q_ctrl;
  q_stat_t                q_stat;
  logic [THREAD_BITS-1:0] q_thread;
  logic [COUNT_BITS-1:0]  q_req;
  logic                   cfg_we;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign alu_mode = (state_r == S_REL) ? ALU_ADD_SAT : ALU_SUB;
  assign alu_b    = (state_r == S_CHK) ? q_req : item_r.count;

  fcs_alu u_alu (
    .mode   (alu_mode),
    .a      (permit_r),
    .b      (alu_b),
    .limit  (limit_r),
    .result (alu_result),
    .ge     (alu_ge)
  );

  fcs_wait_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (q_ctrl),
    .push_thread (item_r.thread_id),
    .push_req    (item_r.count),
    .rd_thread   (q_thread),
    .rd_req      (q_req),
    .stat        (q_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    permit_nxt    = permit_r;
    limit_nxt     = limit_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    q_ctrl        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          unique case (cfg_index)
            REG_INITIAL_PERMITS: begin
              permit_nxt   = cfg_data;
              q_ctrl.clear = 1'b1;
            end
            REG_PERMIT_LIMIT: limit_nxt = cfg_data;
            default: ;
          endcase
        end
        if (start) begin
          item_nxt  = in_data;
          state_nxt = (in_data.op == OP_RELEASE) ? S_REL : S_ACQ;
        end
      end
      S_ACQ: begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.target_thread = item_r.thread_id;
        out_data_nxt.last          = 1'b1;
        if (alu_ge) begin
          permit_nxt        = alu_result;
          out_data_nxt.code = CODE_GRANTED;
        end else if (q_stat.full) begin
          out_data_nxt.code = CODE_REJECTED;
        end else begin
          q_ctrl.push       = 1'b1;
          out_data_nxt.code = CODE_QUEUED;
        end
        out_data_nxt.permits_left = alu_ge ? alu_result : permit_r;
        state_nxt = S_IDLE;
      end
      S_REL: begin
        permit_nxt = alu_result;
        state_nxt  = S_RD;
      end
      S_RD: begin
        if (permit_r == '0 || q_stat.empty) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{target_thread: item_r.thread_id, code: CODE_DONE,
                            permits_left: permit_r, last: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          q_ctrl.rd_en = 1'b1;
          state_nxt    = S_CHK;
        end
      end
      S_CHK: begin
        out_valid_nxt = 1'b1;
        if (alu_ge) begin
          // head fits: wake it and look at the next one
          permit_nxt   = alu_result;
          q_ctrl.pop   = 1'b1;
          out_data_nxt = '{target_thread: q_thread, code: CODE_WOKEN,
                           permits_left: alu_result, last: 1'b0};
          state_nxt    = S_RD;
        end else begin
          out_data_nxt = '{target_thread: item_r.thread_id, code: CODE_DONE,
                           permits_left: permit_r, last: 1'b1};
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      permit_r    <= '0;
      limit_r     <= PERMIT_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      permit_r    <= permit_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/fcs_checker.sv]
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks on the semaphore's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module fcs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input fcs_pkg::out_item_t  out_data
);
  import fcs_pkg::*;

  // more words still to come while a non-final word shows
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-final word with block idle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make block busy");

  a_woken_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.code == CODE_WOKEN |-> !out_data.last)
    else $error("woken word marked last");

  a_acquire_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.code == CODE_GRANTED || out_data.code == CODE_QUEUED ||
                  out_data.code == CODE_REJECTED || out_data.code == CODE_DONE)
    |-> out_data.last)
    else $error("final word not marked last");

endmodule

bind fifo_counting_semaphore fcs_checker u_fcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[bench/fifo_counting_semaphore_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_counting_semaphore_tb
// Self-checking bench for the counting semaphore with a FIFO wait queue.
// A scoreboard tracks permits, the limit and the waiter FIFO, and predicts
// every word for each accepted request. A directed part covers queue full,
// a release that wakes the whole queue, saturation and a lowered limit.
// Random phases then run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module fifo_counting_semaphore_tb;
  import fcs_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 80;
  localparam int PHASE_COUNT   = 6;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED_B = 2'd3;

  class permit_scoreboard;
    logic [COUNT_BITS-1:0]  permits;
    logic [COUNT_BITS-1:0]  limit_val;
    logic [THREAD_BITS-1:0] waiter_tid [QUEUE_DEPTH];
    logic [COUNT_BITS-1:0]  waiter_need [QUEUE_DEPTH];
    int unsigned            head;
    int unsigned            tail;
    int unsigned            waiting;
    out_item_t              expected_words [$];
    int unsigned            failures;
    int unsigned            n_granted, n_queued, n_woken, n_done, n_rejected;

    function new();
      permits   = '0;
      limit_val = PERMIT_LIMIT_RESET;
      head      = 0;
      tail      = 0;
      waiting   = 0;
      failures  = 0;
      n_granted = 0;
      n_queued  = 0;
      n_woken   = 0;
      n_done    = 0;
      n_rejected = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [COUNT_BITS-1:0] val);
      case (idx)
        REG_INITIAL_PERMITS: begin
          permits = val;
          head    = 0;
          tail    = 0;
          waiting = 0;
        end
        REG_PERMIT_LIMIT: begin
          limit_val = val;
        end
        default: ;
      endcase
    endfunction

    function void add_word(logic [THREAD_BITS-1:0] tid, logic [CODE_BITS-1:0] code,
                           logic is_last);
      out_item_t r;
      r.target_thread = tid;
      r.code          = code;
      r.permits_left  = permits;
      r.last          = is_last;
      expected_words.push_back(r);
    endfunction

    function void note_request(in_item_t w);
      logic [COUNT_BITS:0] sum;
      bit                  stop;
      stop = 0;
      if (w.op == OP_ACQUIRE) begin
        if (permits >= w.count) begin
          permits = permits - w.count;
          add_word(w.thread_id, CODE_GRANTED, 1'b1);
        end else if (waiting >= QUEUE_DEPTH) begin
          add_word(w.thread_id, CODE_REJECTED, 1'b1);
        end else begin
          waiter_tid[tail]  = w.thread_id;
          waiter_need[tail] = w.count;
          tail    = (tail + 1) % QUEUE_DEPTH;
          waiting = waiting + 1;
          add_word(w.thread_id, CODE_QUEUED, 1'b1);
        end
      end else begin
        sum = {1'b0, permits} + {1'b0, w.count};
        if (sum > {1'b0, limit_val}) sum = {1'b0, limit_val};
        permits = sum[COUNT_BITS-1:0];
        // wake from the head while permits are nonzero, until the queue is empty or the head's request no longer fits
        while (!stop && permits != 0 && waiting != 0) begin
          if (permits < waiter_need[head]) begin
            stop = 1;
          end else begin
            permits = permits - waiter_need[head];
            add_word(waiter_tid[head], CODE_WOKEN, 1'b0);
            head    = (head + 1) % QUEUE_DEPTH;
            waiting = waiting - 1;
          end
        end
        add_word(w.thread_id, CODE_DONE, 1'b1);
      end
    endfunction

    function void check_word(out_item_t got);
      out_item_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual thread %0d code %0d left %0d last %0d",
                 $time, got.target_thread, got.code, got.permits_left, got.last);
        failures++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.target_thread !== exp_w.target_thread) begin
        $display("%0t: target_thread mismatch, expected %0d, actual %0d",
                 $time, exp_w.target_thread, got.target_thread);
        failures++;
      end
      if (got.code !== exp_w.code) begin
        $display("%0t: code mismatch, expected %0d, actual %0d", $time, exp_w.code, got.code);
        failures++;
      end
      if (got.permits_left !== exp_w.permits_left) begin
        $display("%0t: permits_left mismatch, expected %0d, actual %0d",
                 $time, exp_w.permits_left, got.permits_left);
        failures++;
      end
      if (got.last !== exp_w.last) begin
        $display("%0t: last mismatch, expected %0d, actual %0d", $time, exp_w.last, got.last);
        failures++;
      end
      case (exp_w.code)
        CODE_GRANTED:  n_granted++;
        CODE_QUEUED:   n_queued++;
        CODE_WOKEN:    n_woken++;
        CODE_DONE:     n_done++;
        CODE_REJECTED: n_rejected++;
        default: ;
      endcase
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  in_item_t                in_data;
  logic                    out_valid;
  out_item_t               out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [COUNT_BITS-1:0]   cfg_data;

  permit_scoreboard sb;
  int unsigned      idle_pct;
  int unsigned      cycles;
  int unsigned      reg_writes;

  fifo_counting_semaphore DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_word(out_data);
  end

  function automatic in_item_t req(logic op, logic [THREAD_BITS-1:0] tid,
                                   logic [COUNT_BITS-1:0] cnt);
    in_item_t w;
    w.op        = op;
    w.thread_id = tid;
    w.count     = cnt;
    return w;
  endfunction

  function automatic in_item_t random_req(int unsigned scale);
    in_item_t    w;
    int unsigned sel;
    sel         = $urandom_range(0, 99);
    w.op        = ($urandom_range(0, 99) < 55) ? OP_ACQUIRE : OP_RELEASE;
    w.thread_id = THREAD_BITS'($urandom_range(0, 255));
    if (sel < 50)      w.count = COUNT_BITS'($urandom_range(0, scale));
    else if (sel < 75) w.count = COUNT_BITS'($urandom_range(0, 15));
    else if (sel < 92) w.count = COUNT_BITS'($urandom());
    else               w.count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(w);
  endtask

  // hold off until every expected word is back and the sequencer has settled
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COUNT_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned init_val, limit_val, scale;
    sb         = new();
    cycles     = 0;
    reg_writes = 0;
    idle_pct   = 0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_INITIAL_PERMITS;
    cfg_data   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero-permit grant, fill the queue, reject, wake all sixteen
    send_word(req(OP_ACQUIRE, 8'd0, 16'd0));
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      send_word(req(OP_ACQUIRE, (i == 0) ? 8'hFF : 8'(i * 17), 16'd1));
    end
    send_word(req(OP_ACQUIRE, 8'hAA, 16'd1));
    send_word(req(OP_RELEASE, 8'h55, 16'd0));
    send_word(req(OP_RELEASE, 8'hFF, 16'd16));
    // release into an empty queue brings the permits up to the limit
    send_word(req(OP_RELEASE, 8'h01, 16'hFFFF));
    send_word(req(OP_ACQUIRE, 8'h80, 16'hFFFF));
    wait_drained();

    // initial permits above a lowered limit stay until the next release
    write_cfg(REG_PERMIT_LIMIT, 16'd100);
    write_cfg(REG_INITIAL_PERMITS, 16'd1000);
    send_word(req(OP_ACQUIRE, 8'h11, 16'd500));
    send_word(req(OP_RELEASE, 8'h22, 16'd0));
    send_word(req(OP_ACQUIRE, 8'h33, 16'd200));
    send_word(req(OP_RELEASE, 8'h44, 16'd150));
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin init_val = 0;     limit_val = 65535; scale = 40;    idle_pct = 0;  end
        1: begin init_val = 20;    limit_val = 64;    scale = 24;    idle_pct = 88; end
        2: begin init_val = 65535; limit_val = 65535; scale = 30000; idle_pct = 31; end
        3: begin init_val = 300;   limit_val = 0;     scale = 10;    idle_pct = 0;  end
        4: begin
          init_val = $urandom_range(0, 65535);
          limit_val = $urandom_range(0, 65535);
          scale = 200;
          idle_pct = 88;
        end
        default: begin init_val = 5; limit_val = 200; scale = 60; idle_pct = 31; end
      endcase
      if (p == 2 || p == 4) begin
        write_cfg(REG_UNMAPPED_A, 16'($urandom()));
        write_cfg(REG_UNMAPPED_B, 16'($urandom()));
      end
      write_cfg(REG_PERMIT_LIMIT, limit_val[COUNT_BITS-1:0]);
      write_cfg(REG_INITIAL_PERMITS, init_val[COUNT_BITS-1:0]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_word(random_req(scale));
      end
      wait_drained();
    end

    $display("requests: %0d granted, %0d queued, %0d rejected; releases: %0d, waking %0d",
             sb.n_granted, sb.n_queued, sb.n_rejected, sb.n_done, sb.n_woken);
    $display("register writes: %0d across %0d random phases and the directed part",
             reg_writes, PHASE_COUNT);
    if (sb.failures == 0 && sb.expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
